[hdl/dual_ws2812_pwm_slot_encoder_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared assertion shorthands for the dual WS2812 slot encoder checkers.
// ----------------------------------------------------------------------------
`ifndef DUAL_WS2812_PWM_SLOT_ENCODER_DEFINES_SVH
`define DUAL_WS2812_PWM_SLOT_ENCODER_DEFINES_SVH

// same-cycle implication, off while reset is high
`define DWSPE_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off while reset is high
`define DWSPE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/dwspe_pkg.sv]
// ----------------------------------------------------------------------------
// dwspe_pkg
// Types and constants shared by the dual WS2812 slot encoder modules.
// ----------------------------------------------------------------------------
package dwspe_pkg;

  localparam int CMP_W     = 16;
  localparam int BYTE_W    = 8;
  localparam int SLOTS     = 3 * BYTE_W;
  localparam int SLOT_CNT_W = $clog2(SLOTS);
  localparam int CFG_IDX_W = 1;

  localparam logic [CMP_W-1:0] DUTY_ZERO_RESET = CMP_W'(29);
  localparam logic [CMP_W-1:0] DUTY_ONE_RESET  = CMP_W'(58);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DUTY_ZERO = 1'b0,
    REG_DUTY_ONE  = 1'b1
  } reg_index_t;

  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_RESET = 1'b1
  } op_t;

  typedef struct packed {
    logic push;
    logic single;
    logic last;
    logic err;
  } slot_ctrl_t;

endpackage

[hdl/dwspe_lane.sv]
// ----------------------------------------------------------------------------
// dwspe_lane
// One string lane: shifts the GRB bits out MSB first and picks the duty value.
// ----------------------------------------------------------------------------
module dwspe_lane
  import dwspe_pkg::*;
(
  input  logic              clk,
  input  logic              load,
  input  logic              shift,
  input  logic [BYTE_W-1:0] green,
  input  logic [BYTE_W-1:0] red,
  input  logic [BYTE_W-1:0] blue,
  input  logic [CMP_W-1:0]  duty_zero,
  input  logic [CMP_W-1:0]  duty_one,
  output logic [CMP_W-1:0]  compare
);

  logic [SLOTS-1:0] bits;

  always_ff @(posedge clk) begin
    if (load) begin
      bits <= {green, red, blue};
    end else if (shift) begin
      bits <= {bits[SLOTS-2:0], 1'b0};
    end
  end

  assign compare = bits[SLOTS-1] ? duty_one : duty_zero;

endmodule

[hdl/dwspe_merge.sv]
// ----------------------------------------------------------------------------
// dwspe_merge
// Combines both lane values into one slot and holds it in the output register.
// ----------------------------------------------------------------------------
module dwspe_merge
  import dwspe_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  slot_ctrl_t       ctrl,
  input  logic [CMP_W-1:0] a_lane,
  input  logic [CMP_W-1:0] b_lane,
  input  logic             out_stall,
  output logic             ready,
  output logic             out_valid,
  output logic [CMP_W-1:0] a_compare,
  output logic [CMP_W-1:0] b_compare,
  output logic             run_last,
  output logic             config_error
);

  assign ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ready) begin
      out_valid <= ctrl.push;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && ctrl.push) begin
      a_compare    <= ctrl.single ? '0 : a_lane;
      b_compare    <= ctrl.single ? '0 : b_lane;
      run_last     <= ctrl.last;
      config_error <= ctrl.single && ctrl.err;
    end
  end

endmodule

[hdl/dual_ws2812_pwm_slot_encoder.sv]
// ----------------------------------------------------------------------------
// dual_ws2812_pwm_slot_encoder
// Encodes a pixel pair for two WS2812 strings into 24 PWM compare slots.
// ----------------------------------------------------------------------------
// channel  direction  handshake              beat
// in       sink       in_valid / in_stall    operation + two GRB pixels
// out      source     out_valid / out_stall  one slot: two compares, flags
// cfg      sink       cfg_write              duty register write
//
// A pixel pair yields 24 slots, one slot per cycle unless out_stall holds them, counted by
// the slot counter that steps both lanes; a reset or a bad duty setting yields a single slot.
// The next item is taken in the cycle its predecessor's last slot moves into
// the output register, so slots stream with no gap.
// Reset clears the valids and loads duty_zero = 29, duty_one = 58.
// out_stall on a valid output holds the output register and stops the lanes in place.
// ----------------------------------------------------------------------------
module dual_ws2812_pwm_slot_encoder
  import dwspe_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 operation,
  input  logic [BYTE_W-1:0]    a_green,
  input  logic [BYTE_W-1:0]    a_red,
  input  logic [BYTE_W-1:0]    a_blue,
  input  logic [BYTE_W-1:0]    b_green,
  input  logic [BYTE_W-1:0]    b_red,
  input  logic [BYTE_W-1:0]    b_blue,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [CMP_W-1:0]     a_compare,
  output logic [CMP_W-1:0]     b_compare,
  output logic                 run_last,
  output logic                 config_error,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CMP_W-1:0]     cfg_data
);

  logic [CMP_W-1:0]      duty_zero;
  logic [CMP_W-1:0]      duty_one;
  logic                  cfg_bad;
  logic                  active;
  logic                  single;
  logic [SLOT_CNT_W-1:0] cnt;
  logic                  ready;
  logic                  push;
  logic                  cur_last;
  logic                  done;
  logic                  accept;
  logic [CMP_W-1:0]      a_lane;
  logic [CMP_W-1:0]      b_lane;
  slot_ctrl_t            ctrl;

  always_ff @(posedge clk) begin
    if (rst) begin
      duty_zero <= DUTY_ZERO_RESET;
      duty_one  <= DUTY_ONE_RESET;
    end else if (cfg_write) begin
      unique case (reg_index_t'(cfg_index))
        REG_DUTY_ZERO: duty_zero <= cfg_data;
        REG_DUTY_ONE:  duty_one  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cfg_bad  = duty_zero >= duty_one;
  assign push     = active && ready;
  assign cur_last = single || (cnt == SLOT_CNT_W'(SLOTS - 1));
  assign done     = push && cur_last;
  assign in_stall = active && !done;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      single <= 1'b0;
      cnt    <= '0;
    end else if (accept) begin
      active <= 1'b1;
      single <= (op_t'(operation) == OP_RESET) || cfg_bad;
      cnt    <= '0;
    end else if (done) begin
      active <= 1'b0;
    end else if (push) begin
      cnt <= cnt + SLOT_CNT_W'(1);
    end
  end

  dwspe_lane u_lane_a (
    .clk       (clk),
    .load      (accept),
    .shift     (push),
    .green     (a_green),
    .red       (a_red),
    .blue      (a_blue),
    .duty_zero (duty_zero),
    .duty_one  (duty_one),
    .compare   (a_lane)
  );

  dwspe_lane u_lane_b (
    .clk       (clk),
    .load      (accept),
    .shift     (push),
    .green     (b_green),
    .red       (b_red),
    .blue      (b_blue),
    .duty_zero (duty_zero),
    .duty_one  (duty_one),
    .compare   (b_lane)
  );

  assign ctrl.push   = push;
  assign ctrl.single = single;
  assign ctrl.last   = cur_last;
  assign ctrl.err    = cfg_bad;

  dwspe_merge u_merge (
    .clk          (clk),
    .rst          (rst),
    .ctrl         (ctrl),
    .a_lane       (a_lane),
    .b_lane       (b_lane),
    .out_stall    (out_stall),
    .ready        (ready),
    .out_valid    (out_valid),
    .a_compare    (a_compare),
    .b_compare    (b_compare),
    .run_last     (run_last),
    .config_error (config_error)
  );

endmodule

[hdl/dwspe_checker.sv]
// ----------------------------------------------------------------------------
// dwspe_checker
// Port-level checks for the dual WS2812 slot encoder, bound to the top level.
// ----------------------------------------------------------------------------
`include "dual_ws2812_pwm_slot_encoder_defines.svh"

module dwspe_checker
  import dwspe_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             out_valid,
  input logic             out_stall,
  input logic [CMP_W-1:0] a_compare,
  input logic [CMP_W-1:0] b_compare,
  input logic             run_last,
  input logic             config_error
);

  `DWSPE_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(a_compare) && $stable(b_compare) && $stable(run_last) && $stable(config_error), "stalled output beat changed")

  `DWSPE_ASSERT_NOW(a_err_shape, clk, rst, out_valid && config_error, run_last && (a_compare == '0) && (b_compare == '0), "error beat is not a zero last slot")

  `DWSPE_ASSERT_NEXT(a_run_gapless, clk, rst, out_valid && !out_stall && !run_last, out_valid, "gap inside a slot run")

  `DWSPE_ASSERT_NOW(a_reset_clear, clk, rst, $past(rst), !out_valid, "output valid after reset")

endmodule

bind dual_ws2812_pwm_slot_encoder dwspe_checker u_dwspe_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .a_compare    (a_compare),
  .b_compare    (b_compare),
  .run_last     (run_last),
  .config_error (config_error)
);
